[hw/rtl/small_fast_prng_32_unit_defines.svh]
// ----------------------------------------------------------------------------
// small_fast_prng_32_unit_defines
// Assertion macros shared by the generator RTL.
// ----------------------------------------------------------------------------
`ifndef SMALL_FAST_PRNG_32_UNIT_DEFINES_SVH
`define SMALL_FAST_PRNG_32_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFPRNG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfprng assertion failed");

// Next-cycle implication, checked outside reset.
`define SFPRNG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfprng assertion failed");

`endif

[hw/rtl/sfprng_pkg.sv]
// ----------------------------------------------------------------------------
// sfprng_pkg
// Types, constants and the round function of the small fast 32-bit generator.
// ----------------------------------------------------------------------------
package sfprng_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned WARMUP_W = 6;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [WORD_W-1:0]   WORD_A_INIT  = 32'hf1ea5eed;
   localparam logic [WARMUP_W-1:0] WARMUP_RESET = 6'd42;

   localparam int unsigned ROT_B = 21;
   localparam int unsigned ROT_C = 19;
   localparam int unsigned ROT_D = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_VALUE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_ROUNDS = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WARM
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } prng_state_type;

   function automatic logic [WORD_W-1:0] rotl21(input logic [WORD_W-1:0] v);
      return {v[WORD_W-1-ROT_B:0], v[WORD_W-1:WORD_W-ROT_B]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl19(input logic [WORD_W-1:0] v);
      return {v[WORD_W-1-ROT_C:0], v[WORD_W-1:WORD_W-ROT_C]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl6(input logic [WORD_W-1:0] v);
      return {v[WORD_W-1-ROT_D:0], v[WORD_W-1:WORD_W-ROT_D]};
   endfunction

   function automatic prng_state_type prng_round(input prng_state_type s);
      logic [WORD_W-1:0] e;
      prng_state_type    n;
      e   = s.a - rotl21(s.b);
      n.a = s.b ^ rotl19(s.c);
      n.b = s.c + rotl6(s.d);
      n.c = s.d + e;
      n.d = e + n.a;
      return n;
   endfunction

endpackage

[hw/rtl/small_fast_prng_32_unit.sv]
// Response: registered in the cycle after the request beat for a plain request;
//   for a restart or the first request after reset it follows the warm-up rounds.
// Throughput: one beat per cycle for plain requests unless rsp_ready stalls; a reload
//   holds req_ready low while the single round unit runs the warm-up rounds.
// Reset: synchronous; state returns to a = 0xf1ea5eed, b = c = d = 0, reload pending.
// ----------------------------------------------------------------------------
// small_fast_prng_32_unit
// Four-word jsf-style generator; one shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
`include "small_fast_prng_32_unit_defines.svh"

module small_fast_prng_32_unit
   import sfprng_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_W-1:0]    rsp_random_word,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   state_type             state_ff, state_in;
   prng_state_type        words_ff, words_in;
   prng_state_type        round_out;
   logic                  seeded_ff, seeded_in;
   logic [WARMUP_W-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic [WORD_W-1:0]     seed_ff;
   logic [WARMUP_W-1:0]   warmup_ff;
   logic                  req_fire;
   logic                  reload;

   assign round_out       = prng_round(words_ff);
   assign req_ready       = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire        = req_valid && req_ready;
   assign reload          = req_restart || !seeded_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         warmup_ff <= WARMUP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED_VALUE:    seed_ff   <= csr_wdata;
            CSR_WARMUP_ROUNDS: warmup_ff <= csr_wdata[WARMUP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      words_in     = words_ff;
      seeded_in    = seeded_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (reload) begin
                  words_in.a = WORD_A_INIT;
                  words_in.b = seed_ff;
                  words_in.c = seed_ff;
                  words_in.d = seed_ff;
                  count_in   = warmup_ff;
                  state_in   = ST_WARM;
               end else begin
                  words_in     = round_out;
                  rsp_word_in  = round_out.d;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_WARM: begin
            words_in = round_out;
            if (count_ff == '0) begin
               rsp_word_in  = round_out.d;
               rsp_valid_in = 1'b1;
               seeded_in    = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         words_ff.a   <= WORD_A_INIT;
         words_ff.b   <= '0;
         words_ff.c   <= '0;
         words_ff.d   <= '0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         words_ff     <= words_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   `SFPRNG_ASSERT_SAME(a_warm_no_rsp, clock, reset, state_ff == ST_WARM, !rsp_valid_ff)
   `SFPRNG_ASSERT_NEXT(a_reload_warms, clock, reset, req_fire && reload, state_ff == ST_WARM)
   `SFPRNG_ASSERT_NEXT(a_plain_one_cycle, clock, reset, req_fire && !reload,
                       rsp_valid_ff && state_ff == ST_IDLE)
   `SFPRNG_ASSERT_NEXT(a_warm_done, clock, reset, state_ff == ST_WARM && count_ff == '0,
                       rsp_valid_ff && seeded_ff && state_ff == ST_IDLE)

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for small_fast_prng_32_unit: a bit-accurate generator
// model predicts each response word from the request beats and the register
// writes seen on the ports. Requests and responses carry random gaps and
// stalls. Each phase reprograms the warm-up count, and usually the seed, while the unit is
// idle. A short directed opening is followed by random restart/next traffic.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sfprng_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 70;
   localparam int unsigned MAX_REPORTS = 40;
   localparam logic [WORD_W-1:0] A_START = 32'hf1ea5eed;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_W-1:0]    rsp_random_word;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SEED_VALUE;
   logic [WORD_W-1:0]    csr_wdata = '0;

   bit                   restart_queue[$];
   logic [WORD_W-1:0]    expected_words[$];
   int unsigned          mismatches = 0;
   int unsigned          cycles = 0;
   bit                   req_gaps_on = 1'b1;
   bit                   rsp_stalls_on = 1'b1;
   int unsigned          req_gap_left = 0;
   int unsigned          rsp_hold_left = 0;

   logic [WORD_W-1:0]    gen_a, gen_b, gen_c, gen_d;
   bit                   gen_seeded;
   logic [WORD_W-1:0]    cfg_seed;
   logic [WARMUP_W-1:0]  cfg_warmup;

   small_fast_prng_32_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_random_word (rsp_random_word),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] v,
                                               input int unsigned k);
      return (v << k) | (v >> (WORD_W - k));
   endfunction

   task automatic advance_round(output logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] e;
      e     = gen_a - rol32(gen_b, 21);
      gen_a = gen_b ^ rol32(gen_c, 19);
      gen_b = gen_c + rol32(gen_d, 6);
      gen_c = gen_d + e;
      gen_d = e + gen_a;
      word  = gen_d;
   endtask

   task automatic next_random_word(input bit restart, output logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] dropped;
      if (restart || !gen_seeded) begin
         gen_a = A_START;
         gen_b = cfg_seed;
         gen_c = cfg_seed;
         gen_d = cfg_seed;
         for (int i = 0; i < int'(cfg_warmup); i++)
            advance_round(dropped);
         gen_seeded = 1'b1;
      end
      advance_round(word);
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      if (!enabled)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_restart <= 1'b0;
         req_gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (restart_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_restart <= restart_queue.pop_front();
            req_gap_left = pick_gap(req_gaps_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = 0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold_left = pick_gap(rsp_stalls_on);
      end
   end

   // monitor: track register writes, predict on request beats, check response beats
   always @(posedge clock) begin
      logic [WORD_W-1:0] want;
      if (reset) begin
         gen_a = A_START;
         gen_b = '0;
         gen_c = '0;
         gen_d = '0;
         gen_seeded = 1'b0;
         cfg_seed = '0;
         cfg_warmup = WARMUP_RESET;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SEED_VALUE)
               cfg_seed = csr_wdata;
            else if (csr_index == CSR_WARMUP_ROUNDS)
               cfg_warmup = csr_wdata[WARMUP_W-1:0];
         end
         if (req_valid && req_ready) begin
            next_random_word(req_restart, want);
            expected_words.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %h", rsp_random_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_random_word !== want)
                  report_mismatch($sformatf("random_word %h, want %h",
                                            rsp_random_word, want));
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (restart_queue.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic queue_items(input bit first_restart, input int unsigned count);
      @(negedge clock);
      restart_queue.push_back(first_restart);
      for (int unsigned i = 1; i < count; i++)
         restart_queue.push_back($urandom_range(99) < 4);
   endtask

   initial begin
      logic [WORD_W-1:0]   seed;
      logic [WARMUP_W-1:0] warm;
      int unsigned         pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults: seed 0, 42 warm-up rounds; first plain request still reloads
      @(negedge clock);
      restart_queue = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      wait_idle();

      // zero warm-up with an all-ones seed, back-to-back restarts
      write_csr(CSR_SEED_VALUE, 32'hffffffff);
      write_csr(CSR_WARMUP_ROUNDS, 32'h00000000);
      @(negedge clock);
      restart_queue = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      wait_idle();

      // all-ones write to the warm-up register gives 63
      write_csr(CSR_SEED_VALUE, 32'ha5a5a5a5);
      write_csr(CSR_WARMUP_ROUNDS, 32'hffffffff);
      @(negedge clock);
      restart_queue = '{1'b1, 1'b0, 1'b0};
      wait_idle();

      // upper bits dropped: 20 warm-up rounds; plain request first keeps old state
      write_csr(CSR_SEED_VALUE, 32'h5a5a5a5a);
      write_csr(CSR_WARMUP_ROUNDS, 32'hffffffd4);
      @(negedge clock);
      restart_queue = '{1'b0, 1'b1, 1'b0};
      wait_idle();

      write_csr(CSR_SEED_VALUE, 32'h00000001);
      write_csr(CSR_WARMUP_ROUNDS, 32'h00000001);
      @(negedge clock);
      restart_queue = '{1'b1, 1'b1, 1'b0, 1'b0};
      wait_idle();

      for (int unsigned phase = 0; phase < 8; phase++) begin
         pick = $urandom_range(7);
         seed = (pick == 0) ? '0 : (pick == 1) ? '1 : WORD_W'($urandom());
         case ($urandom_range(5))
            0: warm = '0;
            1: warm = 6'd1;
            2: warm = 6'd20;
            3: warm = 6'd42;
            4: warm = '1;
            default: warm = WARMUP_W'($urandom_range(63));
         endcase
         if ($urandom_range(3) != 0)
            write_csr(CSR_SEED_VALUE, seed);
         write_csr(CSR_WARMUP_ROUNDS,
                   (WORD_W'($urandom()) & ~WORD_W'(6'h3f)) | WORD_W'(warm));
         @(negedge clock);
         req_gaps_on = (phase % 4 != 3) && (phase != 5);
         rsp_stalls_on = (phase % 4 != 1) && (phase != 5);
         queue_items($urandom_range(1), 100);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
